/* rtl/core/stx_length_checksum_deframer_unit_defines.svh */
// ----------------------------------------------------------------------------
// STX length/checksum deframer assertion macros
// Clocked assertion helpers shared by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef STX_LENGTH_CHECKSUM_DEFRAMER_UNIT_DEFINES_SVH
`define STX_LENGTH_CHECKSUM_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check an implication on every clock edge outside reset.
`define STXLCD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("deframer assertion failed");
// Check that a condition never holds outside reset.
`define STXLCD_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("deframer forbidden condition seen");
`else
`define STXLCD_ASSERT(label, clk, rst_n, prop)
`define STXLCD_NEVER(label, clk, rst_n, cond)
`endif

`endif

/* rtl/core/stxlcd_pkg.sv */
// ----------------------------------------------------------------------------
// STX deframer package
// Types and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package stxlcd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;

    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd0;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RST = 8'd34;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2,
        PH_CHECK  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BODY   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BADSUM = 2'd2,
        KIND_BADLEN = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] position;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } t_result;

    typedef struct packed {
        logic    has_result;
        t_result result;
    } t_step;

endpackage

/* rtl/core/stxlcd_in_stage.sv */
// ----------------------------------------------------------------------------
// STX deframer input stage
// Registers one received byte until the frame logic consumes it.
// ----------------------------------------------------------------------------
module stxlcd_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [stxlcd_pkg::BYTE_W-1:0]  i_byte,
    input  logic                           i_advance,
    output logic                           o_valid,
    output logic [stxlcd_pkg::BYTE_W-1:0]  o_byte
);

    logic                          r_valid;
    logic                          n_valid;
    logic [stxlcd_pkg::BYTE_W-1:0] r_byte;
    logic                          w_take;

    assign o_ready = !r_valid || i_advance;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

/* rtl/core/stxlcd_core.sv */
// ----------------------------------------------------------------------------
// STX deframer frame engine
// Tracks frame phase, length, position and checksum; forms one result.
// ----------------------------------------------------------------------------
module stxlcd_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic [stxlcd_pkg::BYTE_W-1:0]  i_byte,
    input  logic [stxlcd_pkg::BYTE_W-1:0]  i_start_code,
    input  logic [stxlcd_pkg::BYTE_W-1:0]  i_max_length,
    output stxlcd_pkg::t_step              o_step
);

    stxlcd_pkg::t_phase            r_phase;
    stxlcd_pkg::t_phase            n_phase;
    logic [stxlcd_pkg::BYTE_W-1:0] r_frame_length;
    logic [stxlcd_pkg::BYTE_W-1:0] n_frame_length;
    logic [stxlcd_pkg::BYTE_W-1:0] r_byte_index;
    logic [stxlcd_pkg::BYTE_W-1:0] n_byte_index;
    logic [stxlcd_pkg::BYTE_W-1:0] r_running_sum;
    logic [stxlcd_pkg::BYTE_W-1:0] n_running_sum;
    logic [stxlcd_pkg::BYTE_W-1:0] w_index_inc;
    logic [stxlcd_pkg::BYTE_W-1:0] w_sum_inc;
    logic                          w_len_bad;

    assign w_index_inc = r_byte_index + 8'd1;
    assign w_sum_inc   = r_running_sum + i_byte;
    assign w_len_bad   = i_byte > i_max_length;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            stxlcd_pkg::PH_HUNT: begin
                if (i_byte == i_start_code) begin
                    n_phase = stxlcd_pkg::PH_LENGTH;
                end
            end
            stxlcd_pkg::PH_LENGTH: begin
                if (w_len_bad || i_byte == 8'd0) begin
                    n_phase = stxlcd_pkg::PH_HUNT;
                end else if (i_byte == 8'd1) begin
                    n_phase = stxlcd_pkg::PH_CHECK;
                end else begin
                    n_phase = stxlcd_pkg::PH_BODY;
                end
            end
            stxlcd_pkg::PH_BODY: begin
                if (w_index_inc >= r_frame_length) begin
                    n_phase = stxlcd_pkg::PH_CHECK;
                end
            end
            stxlcd_pkg::PH_CHECK: begin
                n_phase = stxlcd_pkg::PH_HUNT;
            end
            default: begin
                n_phase = stxlcd_pkg::PH_HUNT;
            end
        endcase
    end

    // Frame counters and result
    always_comb begin
        n_frame_length            = r_frame_length;
        n_byte_index              = r_byte_index;
        n_running_sum             = r_running_sum;
        o_step.has_result         = 1'b0;
        o_step.result.kind        = stxlcd_pkg::KIND_BODY;
        o_step.result.position    = w_index_inc;
        o_step.result.data_byte   = i_byte;
        o_step.result.last        = 1'b0;
        case (r_phase)
            stxlcd_pkg::PH_HUNT: begin
                if (i_byte == i_start_code) begin
                    n_byte_index  = 8'd0;
                    n_running_sum = 8'd0;
                end
            end
            stxlcd_pkg::PH_LENGTH: begin
                o_step.result.position = 8'd1;
                o_step.result.last     = 1'b1;
                if (w_len_bad) begin
                    o_step.has_result  = 1'b1;
                    o_step.result.kind = stxlcd_pkg::KIND_BADLEN;
                end else begin
                    // Zero length: the length byte doubles as the checksum
                    n_frame_length = i_byte;
                    n_running_sum  = i_byte;
                    n_byte_index   = 8'd1;
                    if (i_byte == 8'd0) begin
                        o_step.has_result  = 1'b1;
                        o_step.result.kind = stxlcd_pkg::KIND_GOOD;
                    end
                end
            end
            stxlcd_pkg::PH_BODY: begin
                n_byte_index      = w_index_inc;
                n_running_sum     = w_sum_inc;
                o_step.has_result = 1'b1;
            end
            stxlcd_pkg::PH_CHECK: begin
                o_step.has_result  = 1'b1;
                o_step.result.last = 1'b1;
                o_step.result.kind = (i_byte == r_running_sum) ?
                                     stxlcd_pkg::KIND_GOOD : stxlcd_pkg::KIND_BADSUM;
            end
            default: begin
                o_step.has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= stxlcd_pkg::PH_HUNT;
            r_frame_length <= 8'd0;
            r_byte_index   <= 8'd0;
            r_running_sum  <= 8'd0;
        end else if (i_advance) begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_byte_index   <= n_byte_index;
            r_running_sum  <= n_running_sum;
        end
    end

endmodule

/* rtl/core/stxlcd_out_stage.sv */
// ----------------------------------------------------------------------------
// STX deframer result register
// Holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module stxlcd_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  stxlcd_pkg::t_result   i_result,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output stxlcd_pkg::t_result   o_result
);

    logic                r_valid;
    logic                n_valid;
    stxlcd_pkg::t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/core/stx_length_checksum_deframer_unit.sv */
// ----------------------------------------------------------------------------
// STX length/checksum deframer
// Pulls start/length/body/checksum frames out of a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, i_rx_byte) takes one received byte per
//   transaction. Output channel (o_valid/i_ready) returns at most one result
//   transaction per byte: a body byte with its frame position, or a status
//   (frame good, checksum error, length error) flagged by o_last.
//   Path: a byte is held in the input register, its result in the result register.
//   Throughput: one byte per cycle unless a result is blocked, set by the
//   combinational frame engine between the input and result registers.
//   Stall: while the receiver holds i_ready low, one more byte is still
//   taken into the input register; bytes that give no result keep flowing.
//   Reset (synchronous, i_rst_n low): hunt for the start code, start code 0,
//   max length 34, both registers empty.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 start code, 1 max length); other indexes are ignored. Write only
//   while the block is idle.
// ----------------------------------------------------------------------------
`include "stx_length_checksum_deframer_unit_defines.svh"

module stx_length_checksum_deframer_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte input
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [stxlcd_pkg::BYTE_W-1:0]     i_rx_byte,
    // result output
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_kind,
    output logic [stxlcd_pkg::BYTE_W-1:0]     o_position,
    output logic [stxlcd_pkg::BYTE_W-1:0]     o_data_byte,
    output logic                              o_last,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [stxlcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [stxlcd_pkg::BYTE_W-1:0]     i_cfg_data
);

    logic [stxlcd_pkg::BYTE_W-1:0] r_start_code;
    logic [stxlcd_pkg::BYTE_W-1:0] r_max_length;

    logic                          w_s1_valid;
    logic [stxlcd_pkg::BYTE_W-1:0] w_s1_byte;
    logic                          w_advance;
    logic                          w_out_free;
    stxlcd_pkg::t_step             w_step;
    stxlcd_pkg::t_result           w_out_result;

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= stxlcd_pkg::START_CODE_RST;
            r_max_length <= stxlcd_pkg::MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == stxlcd_pkg::REG_START_CODE) begin
                r_start_code <= i_cfg_data;
            end else if (i_cfg_index == stxlcd_pkg::REG_MAX_LENGTH) begin
                r_max_length <= i_cfg_data;
            end
        end
    end

    // Advance the held byte unless its result would find the result register busy
    assign w_advance = w_s1_valid && (!w_step.has_result || w_out_free);

    stxlcd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_byte    (i_rx_byte),
        .i_advance (w_advance),
        .o_valid   (w_s1_valid),
        .o_byte    (w_s1_byte)
    );

    stxlcd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_byte       (w_s1_byte),
        .i_start_code (r_start_code),
        .i_max_length (r_max_length),
        .o_step       (w_step)
    );

    stxlcd_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_step.has_result),
        .i_result (w_step.result),
        .o_free   (w_out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_out_result)
    );

    assign o_kind      = w_out_result.kind;
    assign o_position  = w_out_result.position;
    assign o_data_byte = w_out_result.data_byte;
    assign o_last      = w_out_result.last;

    // Status results, and only they, close a frame
    `STXLCD_ASSERT(a_last_on_status, i_clk, i_rst_n,
        o_valid |-> (o_last == (o_kind != stxlcd_pkg::KIND_BODY)))
    // Body bytes follow start and length, so never sit at position 0 or 1
    `STXLCD_NEVER(a_body_position, i_clk, i_rst_n,
        o_valid && o_kind == stxlcd_pkg::KIND_BODY && o_position < 8'd2)
    // A held byte that cannot advance stays put
    `STXLCD_ASSERT(a_hold_input, i_clk, i_rst_n,
        (w_s1_valid && !w_advance) |=> (w_s1_valid && $stable(w_s1_byte)))
    // Input backpressure only comes from a blocked byte in the input register
    `STXLCD_ASSERT(a_ready_cause, i_clk, i_rst_n,
        !o_ready |-> (w_s1_valid && w_step.has_result && o_valid && !i_ready))

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// STX length/checksum deframer testbench
// Sends a received-byte stream through the deframer and predicts every body
// byte and frame status in the bench. Directed frames come first, then
// random phases at several start-code and length-limit settings. Both
// handshakes idle at random, and every result is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    // Register indexes that decode to nothing; writes there must be ignored.
    localparam logic [stxlcd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [stxlcd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES  = 8;     // covers bytes in flight that give no result
    localparam int STALL_LIMIT   = 4000;  // cycles with no transaction before timeout
    localparam int PHASE_BYTES   = 130;   // random bytes per phase

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic [stxlcd_pkg::BYTE_W-1:0]        i_rx_byte   = '0;
    logic                                 i_ready     = 1'b0;
    logic                                 i_cfg_we    = 1'b0;
    logic [stxlcd_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [stxlcd_pkg::BYTE_W-1:0]        i_cfg_data  = '0;

    logic                                 o_ready;
    logic                                 o_valid;
    logic [1:0]                           o_kind;
    logic [stxlcd_pkg::BYTE_W-1:0]        o_position;
    logic [stxlcd_pkg::BYTE_W-1:0]        o_data_byte;
    logic                                 o_last;

    always #1 i_clk = ~i_clk;

    stx_length_checksum_deframer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_position  (o_position),
        .o_data_byte (o_data_byte),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [stxlcd_pkg::BYTE_W-1:0] byte_stream[$];        // bytes waiting to be sent
    stxlcd_pkg::t_result           predicted_results[$];  // results still to come
    int                            mismatches = 0;

    bit no_idle  = 1'b0;   // set by the sequencer for stretches without gaps
    int hold_seq = 0;      // bump to ask the receiver for one long hold-off

    // Deframer state as the bench sees it, plus its copy of the registers.
    stxlcd_pkg::t_phase            ph        = stxlcd_pkg::PH_HUNT;
    logic [stxlcd_pkg::BYTE_W-1:0] frm_len   = '0;
    logic [stxlcd_pkg::BYTE_W-1:0] pos_idx   = '0;
    logic [stxlcd_pkg::BYTE_W-1:0] frm_sum   = '0;
    logic [stxlcd_pkg::BYTE_W-1:0] cfg_start = stxlcd_pkg::START_CODE_RST;
    logic [stxlcd_pkg::BYTE_W-1:0] cfg_max   = stxlcd_pkg::MAX_LENGTH_RST;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Advance the deframer by one accepted byte and queue the result it gives.
    task automatic deframe_byte(input logic [stxlcd_pkg::BYTE_W-1:0] b);
        stxlcd_pkg::t_result r;
        bit                  has;
        has = 1'b0;
        r   = '0;
        case (ph)
            stxlcd_pkg::PH_HUNT: begin
                // Drop everything until the start code shows up.
                if (b == cfg_start) begin
                    ph      = stxlcd_pkg::PH_LENGTH;
                    pos_idx = '0;
                    frm_sum = '0;
                end
            end
            stxlcd_pkg::PH_LENGTH: begin
                if (b > cfg_max) begin
                    // Length error: the length byte is never a new start code.
                    ph  = stxlcd_pkg::PH_HUNT;
                    r   = '{kind: stxlcd_pkg::KIND_BADLEN, position: 8'd1,
                            data_byte: b, last: 1'b1};
                    has = 1'b1;
                end else if (b == '0) begin
                    // Empty frame: the length byte doubles as its checksum.
                    ph      = stxlcd_pkg::PH_HUNT;
                    frm_len = '0;
                    frm_sum = '0;
                    pos_idx = 8'd1;
                    r   = '{kind: stxlcd_pkg::KIND_GOOD, position: 8'd1,
                            data_byte: 8'd0, last: 1'b1};
                    has = 1'b1;
                end else begin
                    frm_len = b;
                    frm_sum = b;
                    pos_idx = 8'd1;
                    ph      = (b == 8'd1) ? stxlcd_pkg::PH_CHECK : stxlcd_pkg::PH_BODY;
                end
            end
            stxlcd_pkg::PH_BODY: begin
                pos_idx = pos_idx + 8'd1;
                frm_sum = frm_sum + b;
                if (pos_idx >= frm_len) ph = stxlcd_pkg::PH_CHECK;
                r   = '{kind: stxlcd_pkg::KIND_BODY, position: pos_idx,
                        data_byte: b, last: 1'b0};
                has = 1'b1;
            end
            default: begin
                // Checksum byte; its position wraps when the length is 255.
                ph          = stxlcd_pkg::PH_HUNT;
                r.kind      = (b == frm_sum) ? stxlcd_pkg::KIND_GOOD
                                             : stxlcd_pkg::KIND_BADSUM;
                r.position  = pos_idx + 8'd1;
                r.data_byte = b;
                r.last      = 1'b1;
                has         = 1'b1;
            end
        endcase
        if (has) predicted_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next queued byte, hold it until the transaction
    // ------------------------------------------------------------------------
    int src_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap = 0;
        end else if (!i_valid || o_ready) begin
            if (src_gap > 0) begin
                src_gap--;
                i_valid <= 1'b0;
            end else if (byte_stream.size() > 0) begin
                i_rx_byte <= byte_stream.pop_front();
                i_valid   <= 1'b1;
                if (!no_idle) src_gap = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------------
    int rcv_gap   = 0;
    int hold_cnt  = 0;
    int hold_seen = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rcv_gap  = 0;
            hold_cnt = 0;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_cnt  = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_ready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!no_idle) rcv_gap = pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results, then predict from accepted bytes and writes
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        stxlcd_pkg::t_result want;
        if (!i_rst_n) begin
            ph        = stxlcd_pkg::PH_HUNT;
            frm_len   = '0;
            pos_idx   = '0;
            frm_sum   = '0;
            cfg_start = stxlcd_pkg::START_CODE_RST;
            cfg_max   = stxlcd_pkg::MAX_LENGTH_RST;
        end else begin
            // A result leaving now belongs to an older byte, so check it first.
            if (o_valid && i_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with nothing pending", o_data_byte, 8'h00);
                end else begin
                    want = predicted_results.pop_front();
                    if (o_kind !== want.kind)
                        report_mismatch("kind", 8'(o_kind), 8'(want.kind));
                    if (o_position !== want.position)
                        report_mismatch("position", o_position, want.position);
                    if (o_data_byte !== want.data_byte)
                        report_mismatch("data_byte", o_data_byte, want.data_byte);
                    if (o_last !== want.last)
                        report_mismatch("last", 8'(o_last), 8'(want.last));
                end
            end
            if (i_valid && o_ready) deframe_byte(i_rx_byte);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    stxlcd_pkg::REG_START_CODE: cfg_start = i_cfg_data;
                    stxlcd_pkg::REG_MAX_LENGTH: cfg_max   = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long
    // ------------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------------

    // Hold until the stream is sent, every result is back and the pipe drained.
    task automatic wait_idle();
        while (byte_stream.size() != 0 || i_valid || predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers and one undecoded index; call only while idle.
    task automatic write_settings(input logic [stxlcd_pkg::BYTE_W-1:0] st,
                                  input logic [stxlcd_pkg::BYTE_W-1:0] mx);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= stxlcd_pkg::REG_START_CODE;
        i_cfg_data  <= st;
        @(posedge i_clk);
        i_cfg_index <= stxlcd_pkg::REG_MAX_LENGTH;
        i_cfg_data  <= mx;
        @(posedge i_clk);
        i_cfg_index <= $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
        i_cfg_data  <= 8'($urandom_range(0, 255));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Queue one frame at the current settings; optionally spoil its checksum.
    task automatic push_frame(input logic [stxlcd_pkg::BYTE_W-1:0] len, input bit bad_sum);
        logic [stxlcd_pkg::BYTE_W-1:0] acc;
        logic [stxlcd_pkg::BYTE_W-1:0] b;
        int                            k;
        byte_stream.push_back(cfg_start);
        byte_stream.push_back(len);
        if (len == '0 || len > cfg_max) return;
        acc = len;
        for (k = 1; k < len; k++) begin
            b = 8'($urandom_range(0, 255));
            acc = acc + b;
            byte_stream.push_back(b);
        end
        if (bad_sum) acc = acc ^ 8'($urandom_range(1, 255));
        byte_stream.push_back(acc);
    endtask

    // Mostly well-formed frames with random content, some noise and
    // broken frames, until the queue holds about the given number of bytes.
    task automatic push_traffic(input int budget);
        int                            r;
        int                            k;
        int                            top;
        logic [stxlcd_pkg::BYTE_W-1:0] len;
        while (byte_stream.size() < budget) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                byte_stream.push_back(8'($urandom_range(0, 255)));
            end else if (r < 17) begin
                // Truncated frame: if its length is in range, whatever follows gets taken as its body.
                byte_stream.push_back(cfg_start);
                byte_stream.push_back(8'($urandom_range(0, 255)));
                for (k = $urandom_range(0, 3); k > 0; k--)
                    byte_stream.push_back(8'($urandom_range(0, 255)));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8 || cfg_max == '0) begin
                    len = (r < 50) ? 8'd0 : 8'($urandom_range(0, 255));
                end else if (r < 16 && cfg_max < 8'd255) begin
                    len = 8'($urandom_range(int'(cfg_max) + 1, 255));
                end else begin
                    top = (r < 90) ? 12 : 40;
                    if (top > int'(cfg_max)) top = int'(cfg_max);
                    len = 8'($urandom_range(1, top));
                end
                push_frame(len, $urandom_range(0, 4) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial begin
        int                            p;
        logic [stxlcd_pkg::BYTE_W-1:0] st;
        logic [stxlcd_pkg::BYTE_W-1:0] mx;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: start code 0, limit 34.
        byte_stream.push_back(8'hff);          // noise while hunting
        byte_stream.push_back(8'h55);
        push_frame(8'd0, 1'b0);                // empty frame
        push_frame(8'd1, 1'b0);                // no body, checksum only
        push_frame(8'd1, 1'b1);
        byte_stream.push_back(8'h00);          // body bytes at both extremes
        byte_stream.push_back(8'h03);
        byte_stream.push_back(8'h00);
        byte_stream.push_back(8'hff);
        byte_stream.push_back(8'h02);
        push_frame(8'd35, 1'b0);               // one past the limit
        push_frame(8'd2, 1'b1);
        wait_idle();

        // Length byte equal to the start code and over the limit: drop it,
        // it must not open a new frame.
        write_settings(8'h40, 8'h3f);
        byte_stream.push_back(8'h40);
        byte_stream.push_back(8'h40);
        byte_stream.push_back(8'h02);
        push_frame(8'd2, 1'b0);
        wait_idle();

        // Random phases, extremes of both registers among them.
        for (p = 0; p < 8; p++) begin
            case (p)
                0:       begin st = 8'hff; mx = 8'd255; end
                1:       begin st = 8'h00; mx = 8'd0;   end
                2:       begin st = 8'h7e; mx = 8'd1;   end
                3:       begin st = 8'h02; mx = 8'd34;  end
                5:       begin st = 8'($urandom_range(0, 255)); mx = 8'd16; end
                6:       begin st = 8'haa; mx = 8'd255; end
                default: begin
                    st = 8'($urandom_range(0, 255));
                    mx = 8'($urandom_range(0, 255));
                end
            endcase
            write_settings(st, mx);
            no_idle = (p == 3 || p == 6);
            if (p == 1 || p == 5) hold_seq++;   // stall the output, keep sending
            if (p == 0) begin
                // Full-length frames: the checksum position wraps to zero.
                push_frame(8'd255, 1'b0);
                push_frame(8'd255, 1'b1);
            end
            push_traffic(byte_stream.size() + PHASE_BYTES);
            wait_idle();
        end
        no_idle = 1'b0;

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
